// ===== design/bfc_pkg.sv =====
// bfc_pkg: shared types and constants for the box frustum cull block
// command codes, field widths and the item that travels down the plane chain
// no dependencies
package bfc_pkg;

  localparam int NUM_PLANES_DEF     = 6;
  localparam int CONTAIN_PLANES_DEF = 5;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;
  localparam int NRM_W   = 18;
  localparam int OFF_W   = 41;
  localparam int CRD_W   = 24;
  localparam int PROD_W  = NRM_W + CRD_W;   // one normal times one coordinate
  localparam int SUM_W   = 44;              // three products plus offset, exact

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ISECT   = 2'd1,
    CMD_CONTAIN = 2'd2,
    CMD_SINGLE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic isect_ok;     // no plane so far has all corners outside
    logic contain_ok;   // every containment plane so far holds all corners
    logic single_ok;    // chosen plane holds all corners
  } flags_t;

  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic [NRM_W-1:0]   nx;
    logic [NRM_W-1:0]   ny;
    logic [NRM_W-1:0]   nz;
    logic [OFF_W-1:0]   off;
    logic [CRD_W-1:0]   min_x;
    logic [CRD_W-1:0]   min_y;
    logic [CRD_W-1:0]   min_z;
    logic [CRD_W-1:0]   max_x;
    logic [CRD_W-1:0]   max_y;
    logic [CRD_W-1:0]   max_z;
    flags_t             flags;
  } token_t;

endpackage

// ===== design/bfc_cell.sv =====
// bfc_cell: one frustum plane and its two-stage box test
// holds the plane, captures loads addressed to it, updates the item flags
// depends on bfc_pkg
module bfc_cell #(
  parameter int unsigned PLANE_IDX  = 0,
  parameter bit          IS_CONTAIN = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bfc_pkg::token_t tok_in,
  output bfc_pkg::token_t tok_out
);
  import bfc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(PLANE_IDX);

  // plane storage
  logic signed [NRM_W-1:0] pnx, pny, pnz;
  logic signed [OFF_W-1:0] poff;

  logic load_hit;
  assign load_hit = en && tok_in.valid && (tok_in.cmd == CMD_LOAD) && (tok_in.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      pnx  <= '0;
      pny  <= '0;
      pnz  <= '0;
      poff <= '0;
    end else if (load_hit) begin
      pnx  <= tok_in.nx;
      pny  <= tok_in.ny;
      pnz  <= tok_in.nz;
      poff <= tok_in.off;
    end
  end

  // stage 1: six products, one per axis and box extreme
  logic signed [PROD_W-1:0] lo_next [3];
  logic signed [PROD_W-1:0] hi_next [3];

  always_comb begin
    lo_next[0] = $signed(pnx) * $signed(tok_in.min_x);
    lo_next[1] = $signed(pny) * $signed(tok_in.min_y);
    lo_next[2] = $signed(pnz) * $signed(tok_in.min_z);
    hi_next[0] = $signed(pnx) * $signed(tok_in.max_x);
    hi_next[1] = $signed(pny) * $signed(tok_in.max_y);
    hi_next[2] = $signed(pnz) * $signed(tok_in.max_z);
  end

  token_t                   s1_tok;
  logic signed [PROD_W-1:0] s1_lo [3];
  logic signed [PROD_W-1:0] s1_hi [3];
  logic signed [OFF_W-1:0]  s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tok.valid <= 1'b0;
    end else if (en) begin
      s1_tok <= tok_in;
      s1_lo  <= lo_next;
      s1_hi  <= hi_next;
      s1_off <= poff;
    end
  end

  // stage 2: per axis extremes give the largest and smallest corner sums
  logic signed [PROD_W-1:0] ax_max [3];
  logic signed [PROD_W-1:0] ax_min [3];
  logic signed [SUM_W-1:0]  maxs_next, mins_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ax_max[a] = (s1_lo[a] > s1_hi[a]) ? s1_lo[a] : s1_hi[a];
      ax_min[a] = (s1_lo[a] > s1_hi[a]) ? s1_hi[a] : s1_lo[a];
    end
    maxs_next = SUM_W'(ax_max[0]) + SUM_W'(ax_max[1]) + SUM_W'(ax_max[2]) + SUM_W'(s1_off);
    mins_next = SUM_W'(ax_min[0]) + SUM_W'(ax_min[1]) + SUM_W'(ax_min[2]) + SUM_W'(s1_off);
  end

  token_t                  s2_tok;
  logic signed [SUM_W-1:0] s2_maxs, s2_mins;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tok.valid <= 1'b0;
    end else if (en) begin
      s2_tok  <= s1_tok;
      s2_maxs <= maxs_next;
      s2_mins <= mins_next;
    end
  end

  // flag update from the sign of the extreme sums
  logic all_out, all_in;
  assign all_out = s2_maxs[SUM_W-1];
  assign all_in  = !s2_mins[SUM_W-1];

  always_comb begin
    tok_out = s2_tok;
    tok_out.flags.isect_ok = s2_tok.flags.isect_ok && !all_out;
    if (IS_CONTAIN) begin
      tok_out.flags.contain_ok = s2_tok.flags.contain_ok && all_in;
    end
    if (s2_tok.idx == MY_IDX) begin
      tok_out.flags.single_ok = all_in;
    end
  end

endmodule

// ===== design/box_frustum_cull.sv =====
// box_frustum_cull: top level of the box versus frustum plane test
// a chain of bfc_cell plane cells followed by a result register
// depends on bfc_pkg and bfc_cell
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   input   | in_valid / in_ready  | command, plane_index, new_normal_*, new_offset,
//           |                      | min_*, max_*
//   output  | out_valid / out_ready| visible
//
// one item per cycle while the output is not stalled; each plane cell registers an item
// after the products and again after the extreme sums, and a result register follows
// the last cell
// loads travel down the chain like boxes, so every box sees exactly the planes
// loaded before it; a load leaves no result at the end of the chain
// reset clears all planes to zero and empties the chain
// a result held in the output register with out_ready low freezes the whole
// chain and drops in_ready; bubbles are not squeezed out during a stall
module box_frustum_cull #(
  parameter int NUM_PLANES     = bfc_pkg::NUM_PLANES_DEF,
  parameter int CONTAIN_PLANES = bfc_pkg::CONTAIN_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bfc_pkg::CMD_W-1:0]           command,
  input  logic [bfc_pkg::IDX_W-1:0]           plane_index,
  input  logic signed [bfc_pkg::NRM_W-1:0]    new_normal_x,
  input  logic signed [bfc_pkg::NRM_W-1:0]    new_normal_y,
  input  logic signed [bfc_pkg::NRM_W-1:0]    new_normal_z,
  input  logic signed [bfc_pkg::OFF_W-1:0]    new_offset,
  input  logic signed [bfc_pkg::CRD_W-1:0]    min_x,
  input  logic signed [bfc_pkg::CRD_W-1:0]    min_y,
  input  logic signed [bfc_pkg::CRD_W-1:0]    min_z,
  input  logic signed [bfc_pkg::CRD_W-1:0]    max_x,
  input  logic signed [bfc_pkg::CRD_W-1:0]    max_y,
  input  logic signed [bfc_pkg::CRD_W-1:0]    max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                visible
);
  import bfc_pkg::*;

  // plane count as a value comparable with plane_index
  localparam logic [IDX_W:0] NP_CMP = (IDX_W+1)'(NUM_PLANES);

  // whole chain moves unless a finished result is stuck in the output register
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // item entering the chain, flags start optimistic except the single plane test
  token_t chain [NUM_PLANES+1];

  always_comb begin
    chain[0].valid            = in_valid && en;
    chain[0].cmd              = cmd_t'(command);
    chain[0].idx              = plane_index;
    chain[0].nx               = new_normal_x;
    chain[0].ny               = new_normal_y;
    chain[0].nz               = new_normal_z;
    chain[0].off              = new_offset;
    chain[0].min_x            = min_x;
    chain[0].min_y            = min_y;
    chain[0].min_z            = min_z;
    chain[0].max_x            = max_x;
    chain[0].max_y            = max_y;
    chain[0].max_z            = max_z;
    chain[0].flags.isect_ok   = 1'b1;
    chain[0].flags.contain_ok = 1'b1;
    chain[0].flags.single_ok  = 1'b0;
  end

  // one cell per plane; only the first CONTAIN_PLANES take part in containment
  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    bfc_cell #(
      .PLANE_IDX  (k),
      .IS_CONTAIN (k < CONTAIN_PLANES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // pick the answer for the requested test
  token_t tail;
  logic   vis_next;
  assign tail = chain[NUM_PLANES];

  always_comb begin
    case (tail.cmd)
      CMD_ISECT:   vis_next = tail.flags.isect_ok;
      CMD_CONTAIN: vis_next = tail.flags.contain_ok;
      CMD_SINGLE:  vis_next = tail.flags.single_ok;
      default:     vis_next = 1'b0;
    endcase
  end

  // result register, loads are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid && (tail.cmd != CMD_LOAD);
      visible   <= vis_next;
    end
  end

  // a result only ever comes from a non-load item leaving the last cell
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tail.valid && (tail.cmd != CMD_LOAD)))
    else $error("result without a box item at the chain tail");

  // a stall freezes the chain tail
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(tail))
    else $error("chain moved during an output stall");

  // single plane test on a missing plane never passes
  a_single_range: assert property (@(posedge clk) disable iff (rst)
    (tail.valid && (tail.cmd == CMD_SINGLE) && ({1'b0, tail.idx} >= NP_CMP))
      |-> !tail.flags.single_ok)
    else $error("single plane test passed on a plane index out of range");

endmodule

// ===== tb/box_frustum_cull_test.sv =====
// box_frustum_cull_test: self-checking testbench for the box versus frustum plane test
// drives load and box items, predicts visible from its own plane store, checks in order
// depends on bfc_pkg and box_frustum_cull
module box_frustum_cull_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfc_pkg::*;

  // slack on top of the pipeline depth when draining at the end
  localparam int DRAIN_CYCLES = 2 * NUM_PLANES_DEF + 8;
  // cycles with no handshake on either side before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // long receiver hold-off used to fill the pipeline and push back on the input
  localparam int HOLD_CYCLES  = 300;

  // field extremes
  localparam logic [CRD_W-1:0] CRD_LO = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic [CRD_W-1:0] CRD_HI = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic [NRM_W-1:0] NRM_LO = {1'b1, {(NRM_W-1){1'b0}}};
  localparam logic [NRM_W-1:0] NRM_HI = {1'b0, {(NRM_W-1){1'b1}}};
  localparam logic [OFF_W-1:0] OFF_LO = {1'b1, {(OFF_W-1){1'b0}}};
  localparam logic [OFF_W-1:0] OFF_HI = {1'b0, {(OFF_W-1){1'b1}}};

  // one input item as the tb sees it
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [NRM_W-1:0] nx;
    logic [NRM_W-1:0] ny;
    logic [NRM_W-1:0] nz;
    logic [OFF_W-1:0] off;
    logic [CRD_W-1:0] min_x;
    logic [CRD_W-1:0] min_y;
    logic [CRD_W-1:0] min_z;
    logic [CRD_W-1:0] max_x;
    logic [CRD_W-1:0] max_y;
    logic [CRD_W-1:0] max_z;
  } cull_item_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        command = '0;
  logic [IDX_W-1:0]        plane_index = '0;
  logic signed [NRM_W-1:0] new_normal_x = '0;
  logic signed [NRM_W-1:0] new_normal_y = '0;
  logic signed [NRM_W-1:0] new_normal_z = '0;
  logic signed [OFF_W-1:0] new_offset = '0;
  logic signed [CRD_W-1:0] min_x = '0;
  logic signed [CRD_W-1:0] min_y = '0;
  logic signed [CRD_W-1:0] min_z = '0;
  logic signed [CRD_W-1:0] max_x = '0;
  logic signed [CRD_W-1:0] max_y = '0;
  logic signed [CRD_W-1:0] max_z = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    visible;

  box_frustum_cull dut (.*);

  // predictor copy of the plane store, cleared like the block at reset
  logic signed [NRM_W-1:0] frustum_nx  [NUM_PLANES_DEF] = '{default: '0};
  logic signed [NRM_W-1:0] frustum_ny  [NUM_PLANES_DEF] = '{default: '0};
  logic signed [NRM_W-1:0] frustum_nz  [NUM_PLANES_DEF] = '{default: '0};
  logic signed [OFF_W-1:0] frustum_off [NUM_PLANES_DEF] = '{default: '0};

  // visible values still owed by the block, oldest first
  bit pending_visible[$];

  bit idle_on = 1'b1;     // random bursts of idling on both sides
  int hold_req = 0;       // receiver hold-off request, taken by the receiver process
  int mismatches = 0;
  int n_loads = 0;
  int n_boxes = 0;
  int n_seen_visible = 0;
  int n_checked = 0;

  // free-running clock, 20 ns period
  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // count of the eight box corners on the inner side of plane p
  function automatic int corners_inside(int p, cull_item_t item);
    longint x, y, z, s;
    int     n;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      x = longint'($signed(k[0] ? item.max_x : item.min_x));
      y = longint'($signed(k[1] ? item.max_y : item.min_y));
      z = longint'($signed(k[2] ? item.max_z : item.min_z));
      // exact sum, products are at most 42 bits so a longint never wraps
      s = longint'(frustum_nx[p]) * x + longint'(frustum_ny[p]) * y
        + longint'(frustum_nz[p]) * z + longint'(frustum_off[p]);
      if (s >= 0) n++;
    end
    return n;
  endfunction

  function automatic bit predict_visible(cull_item_t item);
    bit vis;
    int span;
    vis = 1'b1;
    case (item.cmd)
      CMD_ISECT: begin
        // culled as soon as one plane has every corner outside
        for (int p = 0; p < NUM_PLANES_DEF; p++)
          if (corners_inside(p, item) == 0) vis = 1'b0;
      end
      CMD_CONTAIN: begin
        span = (CONTAIN_PLANES_DEF < NUM_PLANES_DEF) ? CONTAIN_PLANES_DEF : NUM_PLANES_DEF;
        for (int p = 0; p < span; p++)
          if (corners_inside(p, item) != 8) vis = 1'b0;
      end
      default: begin
        // single plane; an index past the store never passes
        if (item.idx >= NUM_PLANES_DEF) vis = 1'b0;
        else vis = (corners_inside(item.idx, item) == 8);
      end
    endcase
    return vis;
  endfunction

  // loads past the last plane are dropped by the block
  function automatic void apply_load(cull_item_t item);
    if (item.idx < NUM_PLANES_DEF) begin
      frustum_nx[item.idx]  = item.nx;
      frustum_ny[item.idx]  = item.ny;
      frustum_nz[item.idx]  = item.nz;
      frustum_off[item.idx] = item.off;
    end
  endfunction

  // ---------------------------------------------------------------- item builders

  // every field random, so unused fields toggle on every command
  function automatic cull_item_t random_raw();
    cull_item_t item;
    item.cmd   = cmd_t'($urandom_range(0, 3));
    item.idx   = IDX_W'($urandom);
    item.nx    = NRM_W'($urandom);
    item.ny    = NRM_W'($urandom);
    item.nz    = NRM_W'($urandom);
    item.off   = OFF_W'({$urandom, $urandom});
    item.min_x = CRD_W'($urandom);
    item.min_y = CRD_W'($urandom);
    item.min_z = CRD_W'($urandom);
    item.max_x = CRD_W'($urandom);
    item.max_y = CRD_W'($urandom);
    item.max_z = CRD_W'($urandom);
    return item;
  endfunction

  function automatic cull_item_t make_load(int idx, logic [NRM_W-1:0] nx,
                                           logic [NRM_W-1:0] ny, logic [NRM_W-1:0] nz,
                                           logic [OFF_W-1:0] off);
    cull_item_t item;
    item     = random_raw();
    item.cmd = CMD_LOAD;
    item.idx = IDX_W'(idx);
    item.nx  = nx;
    item.ny  = ny;
    item.nz  = nz;
    item.off = off;
    return item;
  endfunction

  function automatic cull_item_t make_box(cmd_t cmd, int idx,
                                          logic [CRD_W-1:0] lx, logic [CRD_W-1:0] ly,
                                          logic [CRD_W-1:0] lz, logic [CRD_W-1:0] hx,
                                          logic [CRD_W-1:0] hy, logic [CRD_W-1:0] hz);
    cull_item_t item;
    item       = random_raw();
    item.cmd   = cmd;
    item.idx   = IDX_W'(idx);
    item.min_x = lx;
    item.min_y = ly;
    item.min_z = lz;
    item.max_x = hx;
    item.max_y = hy;
    item.max_z = hz;
    return item;
  endfunction

  // plane at scene scale most of the time, so boxes land on both sides
  function automatic cull_item_t random_plane(int idx);
    cull_item_t item;
    longint     sc;
    item = make_load(idx, NRM_W'($urandom), NRM_W'($urandom), NRM_W'($urandom),
                     OFF_W'({$urandom, $urandom}));
    case ($urandom_range(0, 7))
      0: ;  // full-range offset
      1: begin
        // degenerate plane that holds everything
        item.nx  = '0;
        item.ny  = '0;
        item.nz  = '0;
        item.off = OFF_W'($urandom_range(0, 1000));
      end
      default: begin
        sc       = $signed({$urandom, $urandom});
        item.off = OFF_W'(sc >>> $urandom_range(23, 30));
      end
    endcase
    return item;
  endfunction

  // box around a random center with a random size; some full-range noise
  function automatic cull_item_t random_box(cmd_t cmd, int idx);
    cull_item_t item;
    longint     lo[3];
    longint     hi[3];
    longint     c, h;
    item = make_box(cmd, idx, CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom),
                    CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      for (int a = 0; a < 3; a++) begin
        c = longint'($signed($urandom)) >>> 11;
        h = $urandom_range(0, 1 << $urandom_range(2, 20));
        lo[a] = c - h;
        hi[a] = c + h;
      end
      item.min_x = lo[0][CRD_W-1:0];
      item.min_y = lo[1][CRD_W-1:0];
      item.min_z = lo[2][CRD_W-1:0];
      item.max_x = hi[0][CRD_W-1:0];
      item.max_y = hi[1][CRD_W-1:0];
      item.max_z = hi[2][CRD_W-1:0];
    end
    return item;
  endfunction

  function automatic int random_index();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
  endfunction

  // ---------------------------------------------------------------- sender

  // called just after a rising edge; returns just after the edge that took the item
  task automatic send_item(cull_item_t item);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= item.cmd;
    plane_index  <= item.idx;
    new_normal_x <= item.nx;
    new_normal_y <= item.ny;
    new_normal_z <= item.nz;
    new_offset   <= item.off;
    min_x        <= item.min_x;
    min_y        <= item.min_y;
    min_z        <= item.min_z;
    max_x        <= item.max_x;
    max_y        <= item.max_y;
    max_z        <= item.max_z;
    // inputs only move at rising edges, so ready seen at the falling edge holds
    // through the next rising edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    // the item is in; update the plane store or queue the expected answer
    if (item.cmd == CMD_LOAD) begin
      apply_load(item);
      n_loads++;
    end else begin
      pending_visible.push_back(predict_visible(item));
      n_boxes++;
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // random stall bursts, plus a long hold-off counted here when one is requested
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // start a stall burst of random length
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  // sampled at the falling edge, where every signal is settled for the coming rising edge
  initial begin
    bit exp_vis;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_visible.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, got visible=%b", $time, visible);
        end else begin
          exp_vis = pending_visible.pop_front();
          n_checked++;
          if (exp_vis) n_seen_visible++;
          if (visible !== exp_vis) begin
            mismatches++;
            $display("%0t: visible mismatch, expected %b, actual %b", $time, exp_vis, visible);
          end
        end
      end
    end
  end

  // watchdog: too long with no handshake on either channel means a hang
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet, pending_visible.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // all planes zero after reset: every corner sits on a plane, so all tests pass
  // except a single-plane test past the store
  task automatic test_reset_planes();
    send_item(make_box(CMD_ISECT, 0, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_CONTAIN, 3, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_SINGLE, 5, CRD_HI, CRD_HI, CRD_HI, CRD_LO, CRD_LO, CRD_LO));
    send_item(make_box(CMD_SINGLE, 7, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
  endtask

  // extreme normals, offsets and coordinates, dropped loads, inverted boxes,
  // a corner exactly on a plane, and a plane with everything outside
  task automatic test_directed_planes();
    send_item(make_load(0, NRM_HI, NRM_LO, '0, OFF_HI));
    send_item(make_load(5, NRM_LO, NRM_LO, NRM_LO, OFF_LO));
    // loads past the store must not land anywhere
    send_item(make_load(6, NRM_HI, NRM_HI, NRM_HI, OFF_LO));
    send_item(make_load(7, NRM_LO, NRM_HI, NRM_LO, OFF_LO));
    send_item(make_box(CMD_ISECT, 0, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_CONTAIN, 0, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_SINGLE, 0, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_SINGLE, 5, CRD_LO, CRD_LO, CRD_LO, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_SINGLE, 6, '0, '0, '0, '0, '0, '0));
    // minimum above maximum, corners taken as given
    send_item(make_box(CMD_ISECT, 2, CRD_HI, CRD_HI, CRD_HI, CRD_LO, CRD_LO, CRD_LO));
    send_item(make_box(CMD_SINGLE, 5, CRD_HI, '0, CRD_HI, CRD_LO, '0, CRD_LO));
    send_item(make_box(CMD_ISECT, 1, '0, '0, '0, '0, '0, '0));
    // zero offset: origin sits exactly on the plane, far negative corner does not
    send_item(make_load(5, NRM_HI, NRM_HI, NRM_HI, '0));
    send_item(make_box(CMD_SINGLE, 5, CRD_LO, CRD_LO, CRD_LO, CRD_LO, CRD_LO, CRD_LO));
    send_item(make_box(CMD_SINGLE, 5, '0, '0, '0, '0, '0, '0));
    // zero normal with offset -1 puts every corner outside
    send_item(make_load(1, '0, '0, '0, '1));
    send_item(make_box(CMD_ISECT, 1, '0, '0, '0, CRD_HI, CRD_HI, CRD_HI));
    send_item(make_box(CMD_CONTAIN, 1, '0, '0, '0, CRD_HI, CRD_HI, CRD_HI));
  endtask

  // well-formed scenes: a full frustum load, then a stream of boxes with
  // occasional plane updates in between
  task automatic test_random_scenes(int rounds);
    repeat (rounds) begin
      for (int p = 0; p < NUM_PLANES_DEF; p++) begin
        if ($urandom_range(0, 9) == 0) send_item(random_plane($urandom_range(6, 7)));
        send_item(random_plane(p));
      end
      repeat ($urandom_range(15, 35)) begin
        if ($urandom_range(0, 14) == 0)
          send_item(random_plane($urandom_range(0, 7)));
        else
          send_item(random_box(cmd_t'($urandom_range(1, 3)), random_index()));
      end
    end
  endtask

  // raw noise on every field and every command
  task automatic test_random_noise(int count);
    repeat (count) send_item(random_raw());
  endtask

  // receiver holds off while the sender streams back to back, so the chain
  // fills and in_ready has to drop
  task automatic test_output_backpressure(int count);
    idle_on  = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (count) send_item(random_box(cmd_t'($urandom_range(1, 3)), random_index()));
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    // reset held from time zero, then released once
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_planes();
    test_directed_planes();
    test_random_scenes(40);
    test_random_noise(150);
    test_output_backpressure(60);
    // closing stretch with no idling on either side
    idle_on = 1'b0;
    test_random_scenes(4);

    in_valid <= 1'b0;
    while (pending_visible.size() > 0) @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d plane loads and %0d box tests (%0d visible) on all commands,",
             n_loads, n_boxes, n_seen_visible);
    $display("with field extremes, dropped loads, inverted boxes and a long output stall");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches out of %0d results", mismatches, n_checked);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
